// File: rtl/bde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bde_pkg: shared types and constants of the box distance estimator
// Field widths, fixed-point limits, register indexes, iteration counts and the
// reference height table for the object classes.
// ----------------------------------------------------------------------------
package bde_pkg;

	typedef logic [11:0] height_t;

	localparam int ROW_W   = 16;
	localparam int CLASS_W = 8;
	localparam int TRACK_W = 8;
	localparam int DIST_W  = 16;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 2;
	localparam int WEIGHT_W  = 9;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEF_REF = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT  = 2'd2;

	// Register reset values.
	localparam logic [15:0]         FOCAL_RST   = 16'd8000;
	localparam height_t             DEF_REF_RST = 12'd435;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RST  = 9'd102;

	// Weight limits (Q1.8).
	localparam logic [WEIGHT_W-1:0] W_MIN = 9'd13;
	localparam logic [WEIGHT_W-1:0] W_MAX = 9'd256;

	// Shortest box accepted, 2 px in Q12.4.
	localparam logic [ROW_W-1:0] MIN_BOX = 16'd32;

	// Distance limits in Q7.9: 0.1 m and 100 m.
	localparam logic [DIST_W-1:0] DIST_MIN = 16'd51;
	localparam logic [DIST_W-1:0] DIST_MAX = 16'd51200;

	// Half of one LSB after the final shift by eight.
	localparam logic [7:0] EMA_ROUND = 8'h80;

	// Number of classes that have a table entry.
	localparam int ROM_ENTRIES = 80;

	// Iteration counts of the shared add/subtract unit.
	localparam logic [4:0] MUL_STEPS = 5'd12;
	localparam logic [4:0] DIV_STEPS = 5'd30;
	localparam logic [4:0] MOD_STEPS = 5'd8;
	localparam logic [4:0] EMA_STEPS = 5'd9;

	// Reference object heights, Q4.8 meters.
	function automatic height_t ref_height(input logic [6:0] idx);
		height_t h;
		unique case (idx)
			7'd0:  h = 12'd435;  7'd1:  h = 12'd256;  7'd2:  h = 12'd384;  7'd3:  h = 12'd282;
			7'd4:  h = 12'd1280; 7'd5:  h = 12'd819;  7'd6:  h = 12'd1024; 7'd7:  h = 12'd896;
			7'd8:  h = 12'd512;  7'd9:  h = 12'd205;  7'd10: h = 12'd154;  7'd11: h = 12'd256;
			7'd12: h = 12'd307;  7'd13: h = 12'd230;  7'd14: h = 12'd77;   7'd15: h = 12'd90;
			7'd16: h = 12'd128;  7'd17: h = 12'd384;  7'd18: h = 12'd205;  7'd19: h = 12'd358;
			7'd20: h = 12'd768;  7'd21: h = 12'd256;  7'd22: h = 12'd384;  7'd23: h = 12'd1408;
			7'd24: h = 12'd102;  7'd25: h = 12'd256;  7'd26: h = 12'd77;   7'd27: h = 12'd26;
			7'd28: h = 12'd154;  7'd29: h = 12'd64;   7'd30: h = 12'd410;  7'd31: h = 12'd384;
			7'd32: h = 12'd56;   7'd33: h = 12'd256;  7'd34: h = 12'd230;  7'd35: h = 12'd51;
			7'd36: h = 12'd256;  7'd37: h = 12'd512;  7'd38: h = 12'd179;  7'd39: h = 12'd77;
			7'd40: h = 12'd56;   7'd41: h = 12'd31;   7'd42: h = 12'd51;   7'd43: h = 12'd56;
			7'd44: h = 12'd46;   7'd45: h = 12'd38;   7'd46: h = 12'd51;   7'd47: h = 12'd26;
			7'd48: h = 12'd38;   7'd49: h = 12'd26;   7'd50: h = 12'd64;   7'd51: h = 12'd51;
			7'd52: h = 12'd38;   7'd53: h = 12'd77;   7'd54: h = 12'd26;   7'd55: h = 12'd38;
			7'd56: h = 12'd230;  7'd57: h = 12'd205;  7'd58: h = 12'd128;  7'd59: h = 12'd154;
			7'd60: h = 12'd205;  7'd61: h = 12'd205;  7'd62: h = 12'd154;  7'd63: h = 12'd8;
			7'd64: h = 12'd8;    7'd65: h = 12'd5;    7'd66: h = 12'd8;    7'd67: h = 12'd36;
			7'd68: h = 12'd115;  7'd69: h = 12'd128;  7'd70: h = 12'd77;   7'd71: h = 12'd102;
			7'd72: h = 12'd435;  7'd73: h = 12'd64;   7'd74: h = 12'd64;   7'd75: h = 12'd77;
			7'd76: h = 12'd51;   7'd77: h = 12'd102;  7'd78: h = 12'd56;   7'd79: h = 12'd51;
			default: h = 12'd0;
		endcase
		return h;
	endfunction

endpackage

// File: rtl/bde_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bde_in_if: box input channel
// Valid/ready channel that carries one tracked box per beat.
// ----------------------------------------------------------------------------
interface bde_in_if;
	logic                          valid;
	logic                          ready;
	logic [bde_pkg::ROW_W-1:0]     top_row;
	logic [bde_pkg::ROW_W-1:0]     bottom_row;
	logic [bde_pkg::CLASS_W-1:0]   object_class;
	logic [bde_pkg::TRACK_W-1:0]   track_number;

	modport source(output valid, top_row, bottom_row, object_class, track_number,
		input ready);
	modport sink(input valid, top_row, bottom_row, object_class, track_number,
		output ready);
endinterface

// File: rtl/bde_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bde_out_if: distance result channel
// Valid/ready channel that carries one distance estimate per beat.
// ----------------------------------------------------------------------------
interface bde_out_if;
	logic                        valid;
	logic                        ready;
	logic [bde_pkg::DIST_W-1:0]  distance;
	logic                        valid_res;

	modport source(output valid, distance, valid_res, input ready);
	modport sink(input valid, distance, valid_res, output ready);
endinterface

// File: rtl/bbox_distance_estimator_ema.sv
`timescale 1ns / 1ps
// A box shorter than 2 px goes straight to a rejected result beat, the first value of a track
// skips the averaging, and a modulo pass is added when TRACKS is not a power of two and
// below 256. One box at a time: the next input beat can be taken from the cycle after
// the result beat leaves, as all arithmetic steps share the single add/subtract unit.
// Reset: configuration and control registers return to their defaults, then a clearing
// pass over all TRACKS entries empties the track history before the first box is accepted.
// ----------------------------------------------------------------------------
// bbox_distance_estimator_ema: pinhole distance estimator with track smoothing
// Computes ref_height * focal / box_height per box of at least 2 px, clamps it to 0.1..100 m and
// smooths it per track with an exponential moving average.
// ----------------------------------------------------------------------------
module bbox_distance_estimator_ema #(
	parameter int TRACKS  = 256,
	parameter int CLASSES = 80
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bde_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bde_pkg::CFG_W-1:0]        cfg_data,
	bde_in_if.sink                           boxes,
	bde_out_if.source                        estimates
);

	localparam int TRK_W = $clog2(TRACKS);
	// A modulo is needed only when the track number can exceed the table and the
	// table depth is not a power of two (then the low bits already are the modulo).
	localparam bit NEED_MOD = (TRACKS < 256) && ((TRACKS & (TRACKS - 1)) != 0);
	localparam int CLS_LIM  = (CLASSES < bde_pkg::ROM_ENTRIES) ? CLASSES
		: bde_pkg::ROM_ENTRIES;

	// Sequencer states.
	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_MUL   = 4'd2;
	localparam logic [3:0] ST_DIV   = 4'd3;
	localparam logic [3:0] ST_CLAMP = 4'd4;
	localparam logic [3:0] ST_MOD   = 4'd5;
	localparam logic [3:0] ST_READ  = 4'd6;
	localparam logic [3:0] ST_DIFF  = 4'd7;
	localparam logic [3:0] ST_EMA   = 4'd8;
	localparam logic [3:0] ST_OUT   = 4'd9;

	// Configuration registers.
	logic [15:0]                   focal_q;
	bde_pkg::height_t              def_ref_q;
	logic [bde_pkg::WEIGHT_W-1:0]  weight_q;
	logic [bde_pkg::WEIGHT_W-1:0]  weight_wr;

	// Control.
	logic [3:0]        state_q;
	logic [3:0]        state_d;
	logic [4:0]        cnt_q;
	logic              last_step;
	logic [TRK_W-1:0]  clr_q;
	logic              in_beat;

	// Datapath.
	logic [31:0]                  acc_q;
	logic [31:0]                  opnd_q;
	logic [11:0]                  mplr_q;
	logic [16:0]                  rem_q;
	logic [16:0]                  dvsr_q;
	logic [15:0]                  h_q;
	logic [7:0]                   trk_q;
	logic [TRK_W-1:0]             idx_q;
	logic [15:0]                  raw_q;
	logic [15:0]                  dist_q;
	logic                         vres_q;

	// Input side decode.
	logic [15:0]       box_h;
	logic              short_box;
	bde_pkg::height_t  ref_h;

	// Shared add/subtract unit.
	logic [31:0]  add_a;
	logic [31:0]  add_b;
	logic         add_sub;
	logic [31:0]  add_sum;

	// Division step.
	logic [17:0]  rem_sh;
	logic         div_ge;
	logic [16:0]  rem_nx;

	// Clamp.
	logic [29:0]  quot;
	logic [15:0]  raw_clamped;

	// Track history: present bit on top of the Q7.9 smoothed distance.
	logic [16:0]       hist_mem [TRACKS];
	logic [16:0]       rd_q;
	logic              mem_we;
	logic [TRK_W-1:0]  mem_addr;
	logic [16:0]       mem_wdata;

	// ------------------------------------------------------------------------
	// Configuration writes. Zero writes to focal length and default height are
	// dropped; the weight is clamped into its legal range as it is written.
	// ------------------------------------------------------------------------
	always_comb begin
		weight_wr = cfg_data[bde_pkg::WEIGHT_W-1:0];
		if (weight_wr < bde_pkg::W_MIN) begin
			weight_wr = bde_pkg::W_MIN;
		end else if (weight_wr > bde_pkg::W_MAX) begin
			weight_wr = bde_pkg::W_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_q   <= bde_pkg::FOCAL_RST;
			def_ref_q <= bde_pkg::DEF_REF_RST;
			weight_q  <= bde_pkg::WEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bde_pkg::REG_FOCAL: begin
					if (cfg_data != '0) begin
						focal_q <= cfg_data;
					end
				end
				bde_pkg::REG_DEF_REF: begin
					if (cfg_data[11:0] != '0) begin
						def_ref_q <= cfg_data[11:0];
					end
				end
				bde_pkg::REG_WEIGHT: begin
					weight_q <= weight_wr;
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Input decode: box height, short box test and reference height.
	// ------------------------------------------------------------------------
	assign box_h = (boxes.bottom_row >= boxes.top_row) ? (boxes.bottom_row - boxes.top_row)
		: (boxes.top_row - boxes.bottom_row);
	assign short_box = box_h < bde_pkg::MIN_BOX;
	assign ref_h = ({1'b0, boxes.object_class} < 9'(CLS_LIM))
		? bde_pkg::ref_height(boxes.object_class[6:0]) : def_ref_q;

	assign boxes.ready = (state_q == ST_IDLE);
	assign in_beat     = boxes.valid && boxes.ready;
	assign last_step   = (cnt_q == 5'd1);

	// ------------------------------------------------------------------------
	// Shared unit. Multiplication is shift-and-add over the multiplier bits,
	// division is restoring shift-and-subtract with the quotient shifted into
	// the low end of the accumulator as the dividend leaves its top.
	// ------------------------------------------------------------------------
	assign rem_sh = {rem_q, acc_q[31]};

	always_comb begin
		add_a   = acc_q;
		add_b   = '0;
		add_sub = 1'b0;
		case (state_q)
			ST_MUL, ST_EMA: begin
				add_a = acc_q;
				add_b = mplr_q[0] ? opnd_q : '0;
			end
			ST_DIV, ST_MOD: begin
				add_a   = 32'(rem_sh);
				add_b   = 32'(dvsr_q);
				add_sub = 1'b1;
			end
			ST_DIFF: begin
				add_a   = 32'(raw_q);
				add_b   = 32'(rd_q[15:0]);
				add_sub = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign add_sum = add_a + (add_sub ? ~add_b : add_b) + 32'(add_sub);
	assign div_ge  = !add_sum[31];
	assign rem_nx  = div_ge ? add_sum[16:0] : rem_sh[16:0];

	// Quotient after the last division step, clamped to 0.1..100 m.
	assign quot = acc_q[29:0];
	always_comb begin
		if (quot < 30'(bde_pkg::DIST_MIN)) begin
			raw_clamped = bde_pkg::DIST_MIN;
		end else if (quot > 30'(bde_pkg::DIST_MAX)) begin
			raw_clamped = bde_pkg::DIST_MAX;
		end else begin
			raw_clamped = quot[15:0];
		end
	end

	// ------------------------------------------------------------------------
	// Sequencer.
	// ------------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == TRK_W'(TRACKS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (boxes.valid) begin
					state_d = short_box ? ST_OUT : ST_MUL;
				end
			end
			ST_MUL: begin
				if (last_step) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (last_step) begin
					state_d = ST_CLAMP;
				end
			end
			ST_CLAMP: begin
				state_d = NEED_MOD ? ST_MOD : ST_READ;
			end
			ST_MOD: begin
				if (last_step) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_DIFF;
			end
			ST_DIFF: begin
				state_d = rd_q[16] ? ST_EMA : ST_OUT;
			end
			ST_EMA: begin
				if (last_step) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (estimates.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + TRK_W'(1);
			end
			if (in_beat) begin
				cnt_q <= bde_pkg::MUL_STEPS;
			end else if (state_q == ST_MUL && last_step) begin
				cnt_q <= bde_pkg::DIV_STEPS;
			end else if (state_q == ST_CLAMP) begin
				cnt_q <= bde_pkg::MOD_STEPS;
			end else if (state_q == ST_DIFF) begin
				cnt_q <= bde_pkg::EMA_STEPS;
			end else if (state_q == ST_MUL || state_q == ST_DIV || state_q == ST_MOD
				|| state_q == ST_EMA) begin
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Datapath registers.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (boxes.valid) begin
					// Accumulator starts at h so that it ends at 4*ref*focal + h.
					acc_q  <= 32'(box_h);
					opnd_q <= 32'({focal_q, 2'b00});
					mplr_q <= ref_h;
					h_q    <= box_h;
					trk_q  <= boxes.track_number;
					idx_q  <= TRK_W'(boxes.track_number);
					dist_q <= '0;
					vres_q <= 1'b0;
				end
			end
			ST_MUL, ST_EMA: begin
				opnd_q <= {opnd_q[30:0], 1'b0};
				mplr_q <= {1'b0, mplr_q[11:1]};
				if (state_q == ST_MUL && last_step) begin
					// Left-align the 30-bit numerator for the divider.
					acc_q  <= {add_sum[29:0], 2'b00};
					rem_q  <= '0;
					dvsr_q <= {h_q, 1'b0};
				end else begin
					acc_q  <= add_sum;
				end
				if (state_q == ST_EMA && last_step) begin
					dist_q <= add_sum[23:8];
					vres_q <= 1'b1;
				end
			end
			ST_DIV, ST_MOD: begin
				acc_q <= {acc_q[30:0], div_ge};
				rem_q <= rem_nx;
				if (state_q == ST_MOD && last_step) begin
					idx_q <= rem_nx[TRK_W-1:0];
				end
			end
			ST_CLAMP: begin
				raw_q  <= raw_clamped;
				acc_q  <= {trk_q, 24'd0};
				rem_q  <= '0;
				dvsr_q <= 17'(TRACKS);
			end
			ST_DIFF: begin
				// acc = 256*old + 128, then w*(raw - old) is added over the weight bits.
				opnd_q <= add_sum;
				acc_q  <= {8'd0, rd_q[15:0], bde_pkg::EMA_ROUND};
				mplr_q <= 12'(weight_q);
				if (!rd_q[16]) begin
					dist_q <= raw_q;
					vres_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------------
	// Track history memory: one write port shared by the clearing pass and the
	// update, one registered read at the current track index.
	// ------------------------------------------------------------------------
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = idx_q;
		mem_wdata = {1'b1, raw_q};
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_addr  = clr_q;
			mem_wdata = '0;
		end else if (state_q == ST_DIFF && !rd_q[16]) begin
			mem_we = 1'b1;
		end else if (state_q == ST_EMA && last_step) begin
			mem_we    = 1'b1;
			mem_wdata = {1'b1, add_sum[23:8]};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			hist_mem[mem_addr] <= mem_wdata;
		end
		rd_q <= hist_mem[idx_q];
	end

	// ------------------------------------------------------------------------
	// Result beat.
	// ------------------------------------------------------------------------
	assign estimates.valid     = (state_q == ST_OUT);
	assign estimates.distance  = dist_q;
	assign estimates.valid_res = vres_q;

	// ------------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------------
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		boxes.ready |-> !estimates.valid)
		else $error("input taken while a result is pending");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		estimates.valid && !estimates.valid_res |-> estimates.distance == '0)
		else $error("rejected box carries a nonzero distance");

	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		estimates.valid && estimates.valid_res
		|-> estimates.distance >= bde_pkg::DIST_MIN && estimates.distance <= bde_pkg::DIST_MAX)
		else $error("distance outside the clamp range");

	a_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL || state_q == ST_DIV || state_q == ST_MOD || state_q == ST_EMA
		|-> cnt_q != '0)
		else $error("iteration counter ran out inside a loop");

endmodule
